>>> src/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
// Used by every module under src; depends on nothing.

package bpc_pkg;

    // Field widths of the external channels.
    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int IDX_W   = 3;
    localparam int PRES_W  = 18;
    localparam int TEMP_W  = 13;

    // Temperature thresholds in hundredths of a degree.
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_COLD = 1500;

    // Output saturation limits.
    localparam int PRES_MAX     = 262143;
    localparam int TEMP_OUT_MAX = 4095;
    localparam int TEMP_OUT_MIN = -4096;

    // Reciprocal of ten scaled by two to the 23rd, rounded up.
    localparam int RECIP10 = 838861;

    // Calibration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } cfg_idx_t;

    // Calibration words C1 to C6.
    typedef struct packed {
        logic [COEFF_W-1:0] c1;
        logic [COEFF_W-1:0] c2;
        logic [COEFF_W-1:0] c3;
        logic [COEFF_W-1:0] c4;
        logic [COEFF_W-1:0] c5;
        logic [COEFF_W-1:0] c6;
    } coeff_t;

    // First-order terms handed to the second-order correction.
    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic signed [18:0] temp;
        logic signed [35:0] off;
        logic signed [34:0] sens;
        logic [17:0]        t2;
    } fo_t;

    // Corrected terms handed to the pressure and temperature outputs.
    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic signed [19:0] temp;
        logic signed [41:0] off;
        logic signed [39:0] sens;
    } so_t;

endpackage

>>> src/bpc_cfg_regs.sv
// Calibration register file holding the six factory words.
// Depends on bpc_pkg for the register indexes and the coefficient struct.

module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COEFF_W-1:0] cfg_wdata,
    output coeff_t             coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign coeff     = coeff_reg;

    // Decode the register index; indexes past the last word are dropped.
    always_comb begin
        coeff_next = coeff_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SENS:     coeff_next.c1 = cfg_wdata;
                REG_OFF:      coeff_next.c2 = cfg_wdata;
                REG_TCS:      coeff_next.c3 = cfg_wdata;
                REG_TCO:      coeff_next.c4 = cfg_wdata;
                REG_TREF:     coeff_next.c5 = cfg_wdata;
                REG_TEMPSENS: coeff_next.c6 = cfg_wdata;
                default:      coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

endmodule

>>> src/bpc_first_order.sv
// First-order compensation: dT, TEMP, OFF and SENS in three register stages.
// Depends on bpc_pkg for the coefficient and first-order structs.

module bpc_first_order
    import bpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  coeff_t           coeff,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] in_d1,
    input  logic [RAW_W-1:0] in_d2,
    output logic             out_valid,
    input  logic             out_ready,
    output fo_t              out_data
);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] en;

    // Stage 1 registers.
    logic [RAW_W-1:0]   d1_s1_reg;
    logic signed [24:0] dt_reg;
    logic signed [24:0] dt_next;

    // Stage 2 registers.
    logic [RAW_W-1:0]   d1_s2_reg;
    logic signed [41:0] mt_reg, mt_next;
    logic signed [41:0] mo_reg, mo_next;
    logic signed [41:0] ms_reg, ms_next;
    logic signed [49:0] mdd_reg, mdd_next;

    // Stage 3 register.
    fo_t fo_reg;
    fo_t fo_next;

    logic signed [16:0] c3_s;
    logic signed [16:0] c4_s;
    logic signed [16:0] c6_s;
    logic signed [41:0] mt_bias;
    logic signed [41:0] mo_bias;
    logic signed [41:0] ms_bias;

    assign c3_s = $signed({1'b0, coeff.c3});
    assign c4_s = $signed({1'b0, coeff.c4});
    assign c6_s = $signed({1'b0, coeff.c6});

    // A stage advances when it is empty or the one after it advances.
    always_comb begin
        en[2]       = !vld_reg[2] || out_ready;
        en[1]       = !vld_reg[1] || en[2];
        en[0]       = !vld_reg[0] || en[1];
        vld_next[0] = en[0] ? in_valid   : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[2];
    assign out_data  = fo_reg;

    // Stage 1: temperature difference from the reference word.
    assign dt_next = $signed({1'b0, in_d2}) - $signed({1'b0, coeff.c5, 8'd0});

    // Stage 2: the four products of dT.
    always_comb begin
        mt_next  = dt_reg * c6_s;
        mo_next  = dt_reg * c4_s;
        ms_next  = dt_reg * c3_s;
        mdd_next = dt_reg * dt_reg;
    end

    // Stage 3: scale the products with truncation toward zero and add the offsets.
    always_comb begin
        mt_bias      = mt_reg + (mt_reg[41] ? 42'sd8388607 : 42'sd0);
        mo_bias      = mo_reg + (mo_reg[41] ? 42'sd63 : 42'sd0);
        ms_bias      = ms_reg + (ms_reg[41] ? 42'sd127 : 42'sd0);
        fo_next.d1   = d1_s2_reg;
        fo_next.temp = 19'(TEMP_REF) + $signed(mt_bias[41:23]);
        fo_next.off  = $signed({3'b000, coeff.c2, 17'd0}) + $signed(mo_bias[41:6]);
        fo_next.sens = $signed({3'b000, coeff.c1, 16'd0}) + $signed(ms_bias[41:7]);
        fo_next.t2   = mdd_reg[48:31];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            d1_s1_reg <= in_d1;
            dt_reg    <= dt_next;
        end
        if (en[1]) begin
            d1_s2_reg <= d1_s1_reg;
            mt_reg    <= mt_next;
            mo_reg    <= mo_next;
            ms_reg    <= ms_next;
            mdd_reg   <= mdd_next;
        end
        if (en[2]) begin
            fo_reg <= fo_next;
        end
    end

endmodule

>>> src/bpc_second_order.sv
// Second-order correction below 20 degC and below -15 degC, three register stages.
// Depends on bpc_pkg for the first- and second-order structs.

module bpc_second_order
    import bpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  fo_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output so_t  out_data
);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] en;

    // Stage 4 registers.
    fo_t         fo_s4_reg;
    logic [34:0] sq_reg, sq_next;
    logic [34:0] sq2_reg, sq2_next;
    logic        low_reg, low_next;
    logic        frz_reg, frz_next;

    // Stage 5 registers.
    logic [RAW_W-1:0]   d1_s5_reg;
    logic signed [35:0] off_s5_reg;
    logic signed [34:0] sens_s5_reg;
    logic signed [19:0] temp_s5_reg, temp_s5_next;
    logic [39:0]        off2_reg, off2_next;
    logic [38:0]        sens2_reg, sens2_next;
    logic               low_s5_reg;

    // Stage 6 register.
    so_t so_reg;
    so_t so_next;

    logic signed [19:0] below;
    logic signed [19:0] cold;
    logic signed [39:0] below_sq;
    logic signed [39:0] cold_sq;
    logic [40:0]        sq_x61;
    logic [38:0]        sq2_x15;
    logic signed [19:0] temp_ext;

    always_comb begin
        en[2]       = !vld_reg[2] || out_ready;
        en[1]       = !vld_reg[1] || en[2];
        en[0]       = !vld_reg[0] || en[1];
        vld_next[0] = en[0] ? in_valid   : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[2];
    assign out_data  = so_reg;

    // Stage 4: distances below the two thresholds and their squares.
    always_comb begin
        below    = $signed({in_data.temp[18], in_data.temp}) - 20'(TEMP_REF);
        cold     = $signed({in_data.temp[18], in_data.temp}) + 20'(TEMP_COLD);
        below_sq = below * below;
        cold_sq  = cold * cold;
        sq_next  = below_sq[34:0];
        sq2_next = cold_sq[34:0];
        low_next = $signed(in_data.temp) < 19'(TEMP_REF);
        frz_next = $signed(in_data.temp) < -19'(TEMP_COLD);
    end

    // Stage 5: OFF2, SENS2 and the corrected temperature.
    always_comb begin
        sq_x61   = {sq_reg, 6'd0} - {4'd0, sq_reg, 2'd0} + {6'd0, sq_reg};
        sq2_x15  = {sq2_reg, 4'd0} - {4'd0, sq2_reg};
        temp_ext = $signed({fo_s4_reg.temp[18], fo_s4_reg.temp});
        if (low_reg) begin
            off2_next    = {3'd0, sq_x61[40:4]} + (frz_reg ? {1'b0, sq2_x15} : 40'd0);
            sens2_next   = {3'd0, sq_reg, 1'b0} + (frz_reg ? {1'b0, sq2_reg, 3'd0} : 39'd0);
            temp_s5_next = temp_ext - $signed({2'b00, fo_s4_reg.t2});
        end else begin
            off2_next    = '0;
            sens2_next   = '0;
            temp_s5_next = temp_ext;
        end
    end

    // Stage 6: subtract the corrections from OFF and SENS.
    always_comb begin
        so_next.d1   = d1_s5_reg;
        so_next.temp = temp_s5_reg;
        so_next.off  = $signed({{6{off_s5_reg[35]}}, off_s5_reg}) - $signed({2'b00, off2_reg});
        so_next.sens = $signed({{5{sens_s5_reg[34]}}, sens_s5_reg})
                     - $signed({1'b0, sens2_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            fo_s4_reg <= in_data;
            sq_reg    <= sq_next;
            sq2_reg   <= sq2_next;
            low_reg   <= low_next;
            frz_reg   <= frz_next;
        end
        if (en[1]) begin
            d1_s5_reg   <= fo_s4_reg.d1;
            off_s5_reg  <= fo_s4_reg.off;
            sens_s5_reg <= fo_s4_reg.sens;
            temp_s5_reg <= temp_s5_next;
            off2_reg    <= off2_next;
            sens2_reg   <= sens2_next;
            low_s5_reg  <= low_reg;
        end
        if (en[2]) begin
            so_reg <= so_next;
        end
    end

    // At or above 20 degC no correction term may reach the subtraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] && !low_s5_reg |-> off2_reg == '0 && sens2_reg == '0)
        else $error("second-order terms present above the threshold");

    // The cold correction only ever applies on top of the first one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && frz_reg |-> low_reg)
        else $error("cold flag set without the low flag");

endmodule

>>> src/bpc_output.sv
// Final pressure product and scaling, temperature in tenths, and saturation.
// Depends on bpc_pkg for the second-order struct and output limits.

module bpc_output
    import bpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  so_t                      in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PRES_W-1:0]        out_pressure,
    output logic signed [TEMP_W-1:0] out_temperature
);

    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic [5:0] en;

    // Stage 7: partial products of D1 and SENS, temperature magnitude.
    logic [43:0]        plo_reg, plo_next;
    logic signed [44:0] phi_reg, phi_next;
    logic signed [41:0] off_s7_reg;
    logic [19:0]        ta_reg, ta_next;
    logic               tneg_s7_reg;

    // Stage 8: full product, temperature quotient.
    logic signed [63:0] prod_reg, prod_next;
    logic signed [41:0] off_s8_reg;
    logic [16:0]        tq_reg, tq_next;
    logic               tneg_s8_reg;

    // Stage 9: product scaled by two to the 21st, signed temperature.
    logic signed [42:0] q1_reg, q1_next;
    logic signed [41:0] off_s9_reg;
    logic signed [17:0] t10_reg, t10_next;

    // Stage 10: subtract the offset, saturate the temperature.
    logic signed [43:0]       diff_reg, diff_next;
    logic signed [TEMP_W-1:0] t13_s10_reg, t13_next;

    // Stage 11: pressure scaled by two to the 15th.
    logic signed [28:0]       p_reg, p_next;
    logic signed [TEMP_W-1:0] t13_s11_reg;

    // Stage 12: output registers.
    logic [PRES_W-1:0]        pres_reg, pres_next;
    logic signed [TEMP_W-1:0] temp_reg;

    logic [39:0]        tq_full;
    logic signed [63:0] prod_bias;
    logic signed [43:0] diff_bias;

    always_comb begin
        en[5] = !vld_reg[5] || out_ready;
        en[4] = !vld_reg[4] || en[5];
        en[3] = !vld_reg[3] || en[4];
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < 6; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_ready        = en[0];
    assign out_valid       = vld_reg[5];
    assign out_pressure    = pres_reg;
    assign out_temperature = temp_reg;

    // Stage 7: split SENS at bit 20 so that each product stays narrow.
    always_comb begin
        plo_next = in_data.d1 * in_data.sens[19:0];
        phi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);
        ta_next  = in_data.temp[19] ? 20'd0 - in_data.temp : in_data.temp;
    end

    // Stage 8: recombine the product; divide the temperature by ten.
    always_comb begin
        prod_next = $signed({phi_reg[43:0], 20'd0}) + $signed({20'd0, plo_reg});
        tq_full   = ta_reg * 20'(RECIP10);
        tq_next   = tq_full[39:23];
    end

    // Stage 9: truncate the product toward zero, restore the temperature sign.
    always_comb begin
        prod_bias = prod_reg + (prod_reg[63] ? 64'sd2097151 : 64'sd0);
        q1_next   = $signed(prod_bias[63:21]);
        t10_next  = tneg_s8_reg ? 18'sd0 - $signed({1'b0, tq_reg})
                                : $signed({1'b0, tq_reg});
    end

    // Stage 10: subtract OFF, saturate the temperature report.
    always_comb begin
        diff_next = $signed({q1_reg[42], q1_reg}) - $signed({{2{off_s9_reg[41]}}, off_s9_reg});
        if (t10_reg > 18'(TEMP_OUT_MAX)) begin
            t13_next = TEMP_W'(TEMP_OUT_MAX);
        end else if (t10_reg < 18'(TEMP_OUT_MIN)) begin
            t13_next = TEMP_W'(TEMP_OUT_MIN);
        end else begin
            t13_next = $signed(t10_reg[TEMP_W-1:0]);
        end
    end

    // Stage 11: truncate toward zero by two to the 15th.
    always_comb begin
        diff_bias = diff_reg + (diff_reg[43] ? 44'sd32767 : 44'sd0);
        p_next    = $signed(diff_bias[43:15]);
    end

    // Stage 12: saturate the pressure to its range.
    always_comb begin
        if (p_reg[28]) begin
            pres_next = '0;
        end else if (p_reg[27:PRES_W] != '0) begin
            pres_next = PRES_W'(PRES_MAX);
        end else begin
            pres_next = p_reg[PRES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            off_s7_reg  <= in_data.off;
            ta_reg      <= ta_next;
            tneg_s7_reg <= in_data.temp[19];
        end
        if (en[1]) begin
            prod_reg    <= prod_next;
            off_s8_reg  <= off_s7_reg;
            tq_reg      <= tq_next;
            tneg_s8_reg <= tneg_s7_reg;
        end
        if (en[2]) begin
            q1_reg     <= q1_next;
            off_s9_reg <= off_s8_reg;
            t10_reg    <= t10_next;
        end
        if (en[3]) begin
            diff_reg    <= diff_next;
            t13_s10_reg <= t13_next;
        end
        if (en[4]) begin
            p_reg       <= p_next;
            t13_s11_reg <= t13_s10_reg;
        end
        if (en[5]) begin
            pres_reg <= pres_next;
            temp_reg <= t13_s11_reg;
        end
    end

    // The tenths quotient can never exceed the largest temperature over ten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> tq_reg <= 17'd52429)
        else $error("temperature quotient out of range");

    // A blocked middle stage keeps its transaction in place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] && !en[3] |=> vld_reg[2] && $stable(q1_reg) && $stable(t10_reg))
        else $error("stalled stage lost its contents");

endmodule

>>> src/baro_pressure_compensation.sv
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg, bpc_cfg_regs, bpc_first_order, bpc_second_order, bpc_output.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     s_raw_pressure, s_raw_temperature
//   m_        out        m_valid / m_ready     m_pressure_out, m_temperature_out
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// One transaction enters per cycle unless m_ready holds the pipeline; its result passes through
// twelve register stages before m_valid shows it.
// The latency is set by the chain of products from dT through D1*SENS.
// Reset clears the stage valid bits and all six calibration words.
// Each stage advances into an empty slot, so s_ready stays high while bubbles remain.
// Configuration writes are taken in every cycle.

module baro_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [RAW_W-1:0]         s_raw_pressure,
    input  logic [RAW_W-1:0]         s_raw_temperature,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PRES_W-1:0]        m_pressure_out,
    output logic signed [TEMP_W-1:0] m_temperature_out,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [COEFF_W-1:0]       cfg_wdata
);

    coeff_t coeff;
    fo_t    fo_data;
    so_t    so_data;
    logic   fo_valid;
    logic   fo_ready;
    logic   so_valid;
    logic   so_ready;

    // Calibration words.
    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coeff     (coeff)
    );

    // First-order terms.
    bpc_first_order u_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coeff     (coeff),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_d1     (s_raw_pressure),
        .in_d2     (s_raw_temperature),
        .out_valid (fo_valid),
        .out_ready (fo_ready),
        .out_data  (fo_data)
    );

    // Low-temperature corrections.
    bpc_second_order u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_data   (fo_data),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_data  (so_data)
    );

    // Pressure, temperature in tenths, and the output registers.
    bpc_output u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (so_valid),
        .in_ready        (so_ready),
        .in_data         (so_data),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_pressure    (m_pressure_out),
        .out_temperature (m_temperature_out)
    );

endmodule

>>> tb/sv/tb_baro_pressure_compensation.sv
`timescale 1ns / 100ps
// Self-checking testbench for baro_pressure_compensation.
// Predicts compensated pressure and temperature from the calibration words it programs.
// Depends on bpc_pkg and the RTL under src.

module tb_baro_pressure_compensation;
    import bpc_pkg::*;

    // Pipeline depth in register stages, used for settling waits.
    localparam int PIPE_LATENCY = 12;
    localparam longint TIMEOUT_NS = 4_000_000;
    localparam int IDLE_PCT = 9;

    // Register indexes past the last calibration word; writes to them are dropped.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Scale of the dT squared term below 20.00 degC.
    localparam longint DT_SQ_SCALE = 64'sd2147483648;

    // Reference temperature used to place D2 on the second-order thresholds.
    localparam logic [COEFF_W-1:0] EDGE_TREF = 16'h8000;

    // Datasheet example calibration and conversions.
    localparam logic [COEFF_W-1:0] DS_C1 = 16'd46372;
    localparam logic [COEFF_W-1:0] DS_C2 = 16'd43981;
    localparam logic [COEFF_W-1:0] DS_C3 = 16'd29059;
    localparam logic [COEFF_W-1:0] DS_C4 = 16'd27842;
    localparam logic [COEFF_W-1:0] DS_C5 = 16'd31553;
    localparam logic [COEFF_W-1:0] DS_C6 = 16'd28165;
    localparam logic [RAW_W-1:0]   DS_D1 = 24'd6465444;
    localparam logic [RAW_W-1:0]   DS_D2 = 24'd8077636;

    typedef struct packed {
        logic [PRES_W-1:0]        pres;
        logic signed [TEMP_W-1:0] temp;
    } comp_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_pressure = '0;
    logic [RAW_W-1:0]         s_raw_temperature = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [PRES_W-1:0]        m_pressure_out;
    logic signed [TEMP_W-1:0] m_temperature_out;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [COEFF_W-1:0]       cfg_wdata = '0;

    // Calibration words as the block should hold them.
    logic [COEFF_W-1:0] cal_words [0:5] = '{default: '0};
    comp_result_t       pending_results [$];
    int                 mismatch_count = 0;
    int                 sender_idle_pct = IDLE_PCT;
    int                 receiver_stall_pct = IDLE_PCT;
    int                 hold_request = 0;
    int                 hold_left = 0;

    baro_pressure_compensation dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pressure_out    (m_pressure_out),
        .m_temperature_out (m_temperature_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // First- and second-order compensation with the current calibration words.
    function automatic comp_result_t compensate(input logic [RAW_W-1:0] d1_raw,
                                                input logic [RAW_W-1:0] d2_raw);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, below, sq, cold, sq2, t2, off2, sens2, p, t10;
        comp_result_t r;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal_words[REG_SENS]);
        c2 = longint'(cal_words[REG_OFF]);
        c3 = longint'(cal_words[REG_TCS]);
        c4 = longint'(cal_words[REG_TCO]);
        c5 = longint'(cal_words[REG_TREF]);
        c6 = longint'(cal_words[REG_TEMPSENS]);
        dt   = d2 - c5 * 256;
        temp = 2000 + (dt * c6) / 8388608;
        off  = c2 * 131072 + (c4 * dt) / 64;
        sens = c1 * 65536 + (c3 * dt) / 128;
        // Second-order correction below 20.00 degC, with more below -15.00 degC.
        if (temp < longint'(TEMP_REF)) begin
            below = temp - longint'(TEMP_REF);
            sq    = below * below;
            t2    = (dt * dt) / DT_SQ_SCALE;
            off2  = (61 * sq) / 16;
            sens2 = 2 * sq;
            if (temp < -longint'(TEMP_COLD)) begin
                cold  = temp + longint'(TEMP_COLD);
                sq2   = cold * cold;
                off2  = off2 + 15 * sq2;
                sens2 = sens2 + 8 * sq2;
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = ((d1 * sens) / 2097152 - off) / 32768;
        if (p < 0) p = 0;
        if (p > longint'(PRES_MAX)) p = longint'(PRES_MAX);
        t10 = temp / 10;
        if (t10 < longint'(TEMP_OUT_MIN)) t10 = longint'(TEMP_OUT_MIN);
        if (t10 > longint'(TEMP_OUT_MAX)) t10 = longint'(TEMP_OUT_MAX);
        r.pres = p[PRES_W-1:0];
        r.temp = t10[TEMP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sends one sample transaction; valid stays high on return, so back-to-back
    // transactions lower it in between only when the sender idles.
    task automatic send_sample(input logic [RAW_W-1:0] dp, input logic [RAW_W-1:0] dtmp);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= dp;
        s_raw_temperature <= dtmp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(compensate(dp, dtmp));
    endtask

    // Writes one register; the caller lowers cfg_valid after the last write.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx <= REG_TEMPSENS) cal_words[idx] = value;
    endtask

    task automatic load_calibration(input logic [COEFF_W-1:0] c1, c2, c3, c4, c5, c6);
        write_register(REG_SENS, c1);
        write_register(REG_OFF, c2);
        write_register(REG_TCS, c3);
        write_register(REG_TCO, c4);
        write_register(REG_TREF, c5);
        write_register(REG_TEMPSENS, c6);
        cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every outstanding result has been checked.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // Random sample, with D2 often placed near the reference temperature so the
    // cold branches and the 20 degC threshold are reached.
    function automatic void pick_sample(output logic [RAW_W-1:0] dp,
                                        output logic [RAW_W-1:0] dtmp);
        int span;
        logic [RAW_W-1:0] offset;
        case ($urandom_range(9))
            0: dp = '0;
            1: dp = '1;
            default: dp = RAW_W'($urandom);
        endcase
        if ($urandom_range(4) < 2) begin
            dtmp = RAW_W'($urandom);
        end else begin
            span   = $urandom_range(22);
            offset = RAW_W'($urandom_range((1 << span) - 1));
            dtmp   = {cal_words[REG_TREF], 8'h00} + ($urandom_range(1) ? offset : -offset);
        end
    endfunction

    function automatic logic [COEFF_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // Result checker: every result transaction is matched to the oldest expectation.
    always @(posedge aclk) begin : check_results
        comp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no sample outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_pressure_out !== want.pres)
                    report_mismatch($sformatf("pressure got %0d expected %0d",
                                              m_pressure_out, want.pres));
                if (m_temperature_out !== want.temp)
                    report_mismatch($sformatf("temperature got %0d expected %0d",
                                              m_temperature_out, want.temp));
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Reset state: all calibration words zero.
    task automatic test_reset_values();
        send_sample('0, '0);
        send_sample('1, '1);
        drain_results();
    endtask

    // Datasheet calibration with field extremes and alternating bit patterns.
    task automatic test_input_extremes();
        load_calibration(DS_C1, DS_C2, DS_C3, DS_C4, DS_C5, DS_C6);
        send_sample(DS_D1, DS_D2);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample(24'hAAAAAA, 24'h555555);
        send_sample(24'h555555, 24'hAAAAAA);
        drain_results();
    endtask

    // D2 placed on both sides of 20.00 degC and of -15.00 degC (first-order TEMP).
    task automatic test_temperature_regions();
        logic [RAW_W-1:0] base;
        base = {EDGE_TREF, 8'h00};
        load_calibration(DS_C1, DS_C2, DS_C3, DS_C4, EDGE_TREF, 16'hFFFF);
        send_sample(DS_D1, base - 24'd128);
        send_sample(DS_D1, base - 24'd129);
        send_sample(DS_D1, base - 24'd448007);
        send_sample(DS_D1, base - 24'd448135);
        drain_results();
    endtask

    // Pressure and temperature driven past both ends of their output ranges.
    task automatic test_saturation();
        load_calibration(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_sample('1, '1);
        send_sample('0, '1);
        drain_results();
        load_calibration(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample('1, '0);
        send_sample('0, '0);
        drain_results();
    endtask

    // Writes to indexes past the last register must leave the calibration alone.
    task automatic test_ignored_registers();
        load_calibration(DS_C1, DS_C2, DS_C3, DS_C4, DS_C5, DS_C6);
        @(posedge aclk);
        write_register(REG_SPARE_LO, 16'h0000);
        write_register(REG_SPARE_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_sample(DS_D1, DS_D2);
        send_sample(DS_D2, DS_D1);
        drain_results();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        logic [RAW_W-1:0] dp, dtmp;
        sender_idle_pct = 0;
        hold_request    = 120;
        repeat (60) begin
            pick_sample(dp, dtmp);
            send_sample(dp, dtmp);
        end
        sender_idle_pct = IDLE_PCT;
        drain_results();
    endtask

    // Random samples under a series of calibration sets, extremes included.
    task automatic test_random_calibrations();
        logic [RAW_W-1:0] dp, dtmp;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_calibration('0, '0, '0, '0, '0, '0);
                1: load_calibration('1, '1, '1, '1, '1, '1);
                2: load_calibration(DS_C1, DS_C2, DS_C3, DS_C4, DS_C5, DS_C6);
                3: load_calibration('1, '0, '1, '0, '1, '0);
                default: load_calibration(pick_word(), pick_word(), pick_word(),
                                          pick_word(), pick_word(), pick_word());
            endcase
            repeat (230) begin
                pick_sample(dp, dtmp);
                send_sample(dp, dtmp);
            end
            drain_results();
        end
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_streaming();
        logic [RAW_W-1:0] dp, dtmp;
        load_calibration(pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word());
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (300) begin
            pick_sample(dp, dtmp);
            send_sample(dp, dtmp);
        end
        drain_results();
        sender_idle_pct    = IDLE_PCT;
        receiver_stall_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_input_extremes();
        test_temperature_regions();
        test_saturation();
        test_ignored_registers();
        test_backpressure();
        test_random_calibrations();
        test_streaming();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit in case the block stops responding.
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
src/bpc_pkg.sv
src/bpc_cfg_regs.sv
src/bpc_first_order.sv
src/bpc_second_order.sv
src/bpc_output.sv
src/baro_pressure_compensation.sv
tb/sv/tb_baro_pressure_compensation.sv
